/* hdl/atl_pkg.sv */
package atl_pkg;

   localparam int ATL_TOKEN_CAPACITY = 256;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [7:0] COMMENT_MARK_RESET = 8'h23;
   localparam logic [7:0] QUOTE_MARK_RESET   = 8'h22;

   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   localparam logic [0:0] CSR_COMMENT_MARK = 1'd0;
   localparam logic [0:0] CSR_QUOTE_MARK   = 1'd1;

   localparam logic [2:0] KIND_CHAR          = 3'd0;
   localparam logic [2:0] KIND_WORD          = 3'd1;
   localparam logic [2:0] KIND_STRING        = 3'd2;
   localparam logic [2:0] KIND_NUMBER        = 3'd3;
   localparam logic [2:0] KIND_NAMED_POINTER = 3'd4;
   localparam logic [2:0] KIND_POINTER_VALUE = 3'd5;

   typedef enum logic [2:0] {
      LEX_CODE    = 3'b001,
      LEX_STRING  = 3'b010,
      LEX_COMMENT = 3'b100
   } mode_type;

   // classified byte, front to back
   typedef struct packed {
      logic [7:0] src_byte;
      logic       eof;
      logic       is_space;
      logic       is_newline;
      logic       is_comment;
      logic       is_quote;
      logic       is_zero;
      logic       is_at;
      logic       is_x;
      logic       is_dec;
      logic       is_hex;
      logic [3:0] digit;
   } word_type;

endpackage

/* hdl/assembler_token_lexer_core.sv */
// An accepted byte is written into the queue, then popped by the back end into the
// registered result outputs, from which any word that it yields is offered on rsp_.
// Throughput: one byte per cycle unless rsp_stall holds a pending result, set by the
// token state update in the back end; a two-word queue decouples classification from it.
// Reset (synchronous): code mode, empty token, empty queue, no result pending,
// comment mark '#' and quote mark '"'.
module assembler_token_lexer_core
   import atl_pkg::*;
#(
   parameter int TOKEN_CAPACITY = ATL_TOKEN_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_char_byte,
   output logic [7:0]  rsp_char_position,
   output logic [31:0] rsp_token_value,
   output logic [8:0]  rsp_token_length,
   output logic        rsp_token_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   word_type front_word;
   word_type q_word;
   logic     q_full, q_empty, q_pop, q_push;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   atl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .src_byte  (req_source_byte),
      .eof       (req_end_of_file),
      .word      (front_word)
   );

   atl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (front_word),
      .pop       (q_pop),
      .pop_word  (q_word),
      .full      (q_full),
      .empty     (q_empty)
   );

   atl_back #(
      .TOKEN_CAPACITY (TOKEN_CAPACITY)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_word             (q_word),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_char_byte      (rsp_char_byte),
      .rsp_char_position  (rsp_char_position),
      .rsp_token_value    (rsp_token_value),
      .rsp_token_length   (rsp_token_length),
      .rsp_token_overflow (rsp_token_overflow)
   );

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue full and empty at once");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CHAR |->
         rsp_token_length == 9'd0 && rsp_token_value == 32'd0 && !rsp_token_overflow)
      else $error("character word carries token summary fields");

   a_value_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_value != 32'd0 |->
         rsp_kind == KIND_NUMBER || rsp_kind == KIND_POINTER_VALUE)
      else $error("nonzero value on a non-numeric token");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end consumed from an empty queue");

endmodule

/* hdl/atl_front.sv */
module atl_front
   import atl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic [7:0] src_byte,
   input  logic       eof,
   output word_type   word
);

   logic [7:0] comment_mark_ff, comment_mark_in;
   logic [7:0] quote_mark_ff, quote_mark_in;
   logic [7:0] sub;
   logic       dec, hex;

   always_comb begin
      comment_mark_in = comment_mark_ff;
      quote_mark_in   = quote_mark_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COMMENT_MARK: comment_mark_in = csr_data;
            CSR_QUOTE_MARK:   quote_mark_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_mark_ff <= COMMENT_MARK_RESET;
         quote_mark_ff   <= QUOTE_MARK_RESET;
      end else begin
         comment_mark_ff <= comment_mark_in;
         quote_mark_ff   <= quote_mark_in;
      end
   end

   always_comb begin
      dec = 1'b0;
      hex = 1'b0;
      sub = 8'd0;
      if (src_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
         dec = 1'b1;
         hex = 1'b1;
         sub = CHAR_ZERO;
      end else if (src_byte inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         hex = 1'b1;
         sub = CHAR_LOWER_A - 8'd10;
      end else if (src_byte inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         hex = 1'b1;
         sub = CHAR_UPPER_A - 8'd10;
      end
   end

   always_comb begin
      word.src_byte   = src_byte;
      word.eof        = eof;
      word.is_space   = (src_byte == CHAR_SPACE) || (src_byte == CHAR_NEWLINE)
                        || (src_byte == CHAR_TAB);
      word.is_newline = (src_byte == CHAR_NEWLINE);
      word.is_comment = (src_byte == comment_mark_ff);
      word.is_quote   = (src_byte == quote_mark_ff);
      word.is_zero    = (src_byte == CHAR_ZERO);
      word.is_at      = (src_byte == CHAR_AT);
      word.is_x       = (src_byte == CHAR_LOWER_X);
      word.is_dec     = dec;
      word.is_hex     = hex;
      word.digit      = 4'(src_byte - sub);
   end

endmodule

/* hdl/atl_queue.sv */
module atl_queue
   import atl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   input  logic     pop,
   output word_type pop_word,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   word_type           store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_word = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* hdl/atl_back.sv */
module atl_back
   import atl_pkg::*;
#(
   parameter int TOKEN_CAPACITY = ATL_TOKEN_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  word_type    q_word,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_char_byte,
   output logic [7:0]  rsp_char_position,
   output logic [31:0] rsp_token_value,
   output logic [8:0]  rsp_token_length,
   output logic        rsp_token_overflow
);

   localparam int LEN_W = $clog2(TOKEN_CAPACITY + 1);

   mode_type          mode_ff, mode_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [2:0]        prefix_ff, prefix_in;
   logic [2:0]        digits_ff, digits_in;
   logic [31:0]       dec_ff, dec_in;
   logic [31:0]       phex_ff, phex_in;
   logic [31:0]       ptr_ff, ptr_in;
   logic              ovf_ff, ovf_in;

   logic              out_valid_ff, out_valid_in;
   logic [2:0]        out_kind_ff, out_kind_in;
   logic [7:0]        out_char_ff, out_char_in;
   logic [7:0]        out_pos_ff, out_pos_in;
   logic [31:0]       out_value_ff, out_value_in;
   logic [8:0]        out_len_ff, out_len_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              out_free;
   logic              do_keep, do_clear, do_finish, do_string;
   logic              at_cap, pos_zero, pos_one;
   logic [31:0]       len_ext;
   logic [2:0]        fin_kind;
   logic [31:0]       fin_value;
   word_type          w;

   assign w        = q_word;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign q_pop    = !q_empty && out_free;
   assign at_cap   = (len_ff >= LEN_W'(TOKEN_CAPACITY));
   assign pos_zero = (len_ff == '0);
   assign pos_one  = (len_ff == LEN_W'(1));
   assign len_ext  = 32'(len_ff);

   always_comb begin
      fin_value = 32'd0;
      if (prefix_ff[1]) begin
         fin_kind  = KIND_NUMBER;
         fin_value = phex_ff;
      end else if (digits_ff[0]) begin
         fin_kind  = KIND_NUMBER;
         fin_value = dec_ff;
      end else if (prefix_ff[2]) begin
         if (digits_ff[1]) begin
            fin_kind  = KIND_POINTER_VALUE;
            fin_value = ptr_ff;
         end else begin
            fin_kind = KIND_NAMED_POINTER;
         end
      end else begin
         fin_kind = KIND_WORD;
      end
   end

   always_comb begin
      do_keep   = 1'b0;
      do_clear  = 1'b0;
      do_finish = 1'b0;
      do_string = 1'b0;
      mode_in   = mode_ff;
      if (q_pop) begin
         if (w.eof) begin
            do_clear = 1'b1;
            mode_in  = LEX_CODE;
         end else begin
            case (mode_ff)
               LEX_COMMENT: begin
                  if (w.is_newline) mode_in = LEX_CODE;
               end
               LEX_STRING: begin
                  if (w.is_quote) begin
                     do_string = 1'b1;
                     do_clear  = 1'b1;
                     mode_in   = LEX_CODE;
                  end else begin
                     do_keep = 1'b1;
                  end
               end
               default: begin
                  mode_in = LEX_CODE;
                  if (w.is_space) begin
                     do_finish = 1'b1;
                  end else if (w.is_comment) begin
                     do_finish = 1'b1;
                     mode_in   = LEX_COMMENT;
                  end else if (w.is_quote) begin
                     do_finish = 1'b1;
                     mode_in   = LEX_STRING;
                  end else begin
                     do_keep = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      len_in    = len_ff;
      prefix_in = prefix_ff;
      digits_in = digits_ff;
      dec_in    = dec_ff;
      phex_in   = phex_ff;
      ptr_in    = ptr_ff;
      ovf_in    = ovf_ff;

      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_char_in  = out_char_ff;
      out_pos_in   = out_pos_ff;
      out_value_in = out_value_ff;
      out_len_in   = out_len_ff;
      out_ovf_in   = out_ovf_ff;

      if (do_keep) begin
         if (at_cap) begin
            ovf_in = 1'b1;
         end else begin
            if (pos_zero) begin
               if (w.is_zero) prefix_in[0] = 1'b1;
               if (w.is_at)   prefix_in[2] = 1'b1;
            end else if (pos_one) begin
               if (prefix_ff[0] && w.is_x) prefix_in[1] = 1'b1;
            end
            if (digits_ff[0]) begin
               if (w.is_dec) dec_in = (dec_ff << 3) + (dec_ff << 1) + 32'(w.digit);
               else          digits_in[0] = 1'b0;
            end
            if (!pos_zero && digits_ff[1]) begin
               if (w.is_hex) ptr_in = {ptr_ff[27:0], w.digit};
               else          digits_in[1] = 1'b0;
            end
            if (!pos_zero && !pos_one && digits_ff[2]) begin
               if (w.is_hex) phex_in = {phex_ff[27:0], w.digit};
               else          digits_in[2] = 1'b0;
            end
            len_in       = len_ff + 1'b1;
            out_valid_in = 1'b1;
            out_kind_in  = KIND_CHAR;
            out_char_in  = w.src_byte;
            out_pos_in   = len_ext[7:0];
            out_value_in = 32'd0;
            out_len_in   = 9'd0;
            out_ovf_in   = 1'b0;
         end
      end

      if (do_finish && !pos_zero) begin
         out_valid_in = 1'b1;
         out_kind_in  = fin_kind;
         out_char_in  = 8'd0;
         out_pos_in   = 8'd0;
         out_value_in = fin_value;
         out_len_in   = len_ext[8:0];
         out_ovf_in   = ovf_ff;
      end

      if (do_string) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_STRING;
         out_char_in  = 8'd0;
         out_pos_in   = 8'd0;
         out_value_in = 32'd0;
         out_len_in   = len_ext[8:0];
         out_ovf_in   = ovf_ff;
      end

      if (do_clear || do_finish) begin
         len_in    = '0;
         prefix_in = 3'b000;
         digits_in = 3'b111;
         dec_in    = 32'd0;
         phex_in   = 32'd0;
         ptr_in    = 32'd0;
         ovf_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= LEX_CODE;
         len_ff       <= '0;
         prefix_ff    <= 3'b000;
         digits_ff    <= 3'b111;
         dec_ff       <= 32'd0;
         phex_ff      <= 32'd0;
         ptr_ff       <= 32'd0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         prefix_ff    <= prefix_in;
         digits_ff    <= digits_in;
         dec_ff       <= dec_in;
         phex_ff      <= phex_in;
         ptr_ff       <= ptr_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_char_ff  <= out_char_in;
      out_pos_ff   <= out_pos_in;
      out_value_ff <= out_value_in;
      out_len_ff   <= out_len_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_char_byte      = out_char_ff;
   assign rsp_char_position  = out_pos_ff;
   assign rsp_token_value    = out_value_ff;
   assign rsp_token_length   = out_len_ff;
   assign rsp_token_overflow = out_ovf_ff;

endmodule
